// ----- rtl/core/olsa_pkg.sv -----
// package for the ordered list shift array
// holds sizes, command and status codes, controller states, item structs and chain control types
// no dependencies
`default_nettype none

package olsa_pkg;

  // list sizing
  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  // common width for comparing the 5-bit position fields against the count
  localparam int POS_W      = (CNT_W > 5) ? CNT_W : 5;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // command codes
  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_INSERT     = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_POP_FRONT  = 3'd4,
    CMD_ERASE      = 3'd5,
    CMD_READ       = 3'd6,
    CMD_FIND       = 3'd7
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BADPOS = 2'd3
  } status_t;

  // controller states
  typedef enum logic {
    S_IDLE,
    S_SHIFT
  } state_t;

  // what the cell row does at each clock edge
  typedef enum logic [1:0] {
    CHAIN_HOLD,   // every cell keeps its word
    CHAIN_LOAD,   // the cell at base takes the word
    CHAIN_UP,     // cells above base take the lower neighbor, base takes the word
    CHAIN_DOWN    // cells at and above base take the upper neighbor
  } chain_mode_t;

  typedef struct packed {
    chain_mode_t mode;
    cnt_t        base;
    word_t       word;
  } chain_cmd_t;

  // request item
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] value;
    logic [4:0]  position;
    logic [4:0]  run_length;
  } req_item_t;

  // response item
  typedef struct packed {
    status_t     status;
    logic [31:0] read_data;
    logic        found;
    logic [3:0]  found_index;
    logic [4:0]  fill_count;
  } rsp_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/olsa_cell.sv -----
// one storage cell of the list row
// holds one word, shifts to or from its neighbors and compares against the key
// depends on olsa_pkg
`default_nettype none

module olsa_cell (
  input  wire logic                 clk,
  input  wire olsa_pkg::chain_cmd_t chain,
  input  wire olsa_pkg::idx_t       cell_index,
  input  wire olsa_pkg::word_t      lower,
  input  wire olsa_pkg::word_t      upper,
  output olsa_pkg::word_t           data,
  output logic                      match
);

  olsa_pkg::cnt_t my_index;

  assign my_index = olsa_pkg::cnt_t'(cell_index);

  // word register, source chosen by the row command and this cell's place
  always_ff @(posedge clk) begin
    case (chain.mode)
      olsa_pkg::CHAIN_LOAD: begin
        if (my_index == chain.base) data <= chain.word;
      end
      olsa_pkg::CHAIN_UP: begin
        if (my_index == chain.base) data <= chain.word;
        else if (my_index > chain.base) data <= lower;
      end
      olsa_pkg::CHAIN_DOWN: begin
        if (my_index >= chain.base) data <= upper;
      end
      default: begin
      end
    endcase
  end

  // compare against the search key
  assign match = (data == chain.word);

endmodule

`default_nettype wire

// ----- rtl/core/olsa_ctrl.sv -----
// command decoder and sequencer for the ordered list shift array
// keeps the fill count, drives the cell row and builds the response item
// depends on olsa_pkg
`default_nettype none

module olsa_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_ready,
  input  wire olsa_pkg::req_item_t   req,
  output logic                       rsp_valid,
  input  wire logic                  rsp_ready,
  output olsa_pkg::rsp_item_t        rsp,
  output olsa_pkg::chain_cmd_t       chain,
  input  wire olsa_pkg::word_t       cell_data [olsa_pkg::CAPACITY],
  input  wire logic [olsa_pkg::CAPACITY-1:0] cell_match
);

  olsa_pkg::state_t  state, state_next;
  olsa_pkg::cnt_t    count, count_next;
  olsa_pkg::cnt_t    erase_base;
  olsa_pkg::cnt_t    remaining;
  logic              accept;

  // decoded request
  olsa_pkg::status_t     dec_status;
  olsa_pkg::word_t       dec_rdata;
  logic                  dec_found;
  olsa_pkg::idx_t        dec_fidx;
  olsa_pkg::chain_mode_t dec_mode;
  olsa_pkg::cnt_t        dec_base;
  logic                  dec_multi;

  logic [olsa_pkg::POS_W-1:0] pos_w, run_w, cnt_w;
  logic [olsa_pkg::POS_W:0]   end_w;
  logic [olsa_pkg::CAPACITY-1:0] hit;
  logic                  any_hit;
  olsa_pkg::idx_t        hit_idx;
  logic                  full;

  assign accept = req_valid && req_ready;
  assign pos_w  = olsa_pkg::POS_W'(req.position);
  assign run_w  = olsa_pkg::POS_W'(req.run_length);
  assign cnt_w  = olsa_pkg::POS_W'(count);
  assign end_w  = {1'b0, pos_w} + {1'b0, run_w};
  assign full   = (count == olsa_pkg::cnt_t'(olsa_pkg::CAPACITY));

  // first match among the occupied cells
  always_comb begin
    hit     = '0;
    any_hit = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < olsa_pkg::CAPACITY; i++) begin
      hit[i] = cell_match[i] && (olsa_pkg::cnt_t'(i) < count);
    end
    for (int i = olsa_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (hit[i]) begin
        any_hit = 1'b1;
        hit_idx = olsa_pkg::idx_t'(i);
      end
    end
  end

  // command decode
  always_comb begin
    dec_status = olsa_pkg::STAT_OK;
    dec_rdata  = '0;
    dec_found  = 1'b0;
    dec_fidx   = '0;
    dec_mode   = olsa_pkg::CHAIN_HOLD;
    dec_base   = '0;
    dec_multi  = 1'b0;
    count_next = count;
    case (req.cmd)
      olsa_pkg::CMD_PUSH_BACK: begin
        if (full) dec_status = olsa_pkg::STAT_FULL;
        else begin
          dec_mode   = olsa_pkg::CHAIN_LOAD;
          dec_base   = count;
          count_next = count + 1'b1;
        end
      end
      olsa_pkg::CMD_PUSH_FRONT: begin
        if (full) dec_status = olsa_pkg::STAT_FULL;
        else begin
          dec_mode   = olsa_pkg::CHAIN_UP;
          count_next = count + 1'b1;
        end
      end
      olsa_pkg::CMD_INSERT: begin
        if (pos_w > cnt_w) dec_status = olsa_pkg::STAT_BADPOS;
        else if (full) dec_status = olsa_pkg::STAT_FULL;
        else begin
          dec_mode   = olsa_pkg::CHAIN_UP;
          dec_base   = olsa_pkg::cnt_t'(req.position);
          count_next = count + 1'b1;
        end
      end
      olsa_pkg::CMD_POP_BACK: begin
        if (count == '0) dec_status = olsa_pkg::STAT_EMPTY;
        else count_next = count - 1'b1;
      end
      olsa_pkg::CMD_POP_FRONT: begin
        if (count == '0) dec_status = olsa_pkg::STAT_EMPTY;
        else begin
          dec_mode   = olsa_pkg::CHAIN_DOWN;
          count_next = count - 1'b1;
        end
      end
      olsa_pkg::CMD_ERASE: begin
        if (count == '0) dec_status = olsa_pkg::STAT_EMPTY;
        else if (pos_w >= cnt_w) dec_status = olsa_pkg::STAT_BADPOS;
        else if (end_w > {1'b0, cnt_w}) begin
          // run passes the end: truncate at the start
          count_next = olsa_pkg::cnt_t'(req.position);
        end else if (run_w != '0) begin
          dec_mode   = olsa_pkg::CHAIN_DOWN;
          dec_base   = olsa_pkg::cnt_t'(req.position);
          dec_multi  = (run_w > olsa_pkg::POS_W'(1));
          count_next = count - olsa_pkg::cnt_t'(req.run_length);
        end
      end
      olsa_pkg::CMD_READ: begin
        if (pos_w >= cnt_w) dec_status = olsa_pkg::STAT_BADPOS;
        else dec_rdata = cell_data[olsa_pkg::idx_t'(req.position)];
      end
      olsa_pkg::CMD_FIND: begin
        dec_found = any_hit;
        dec_fidx  = hit_idx;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      olsa_pkg::S_IDLE: begin
        if (accept && dec_multi) state_next = olsa_pkg::S_SHIFT;
      end
      olsa_pkg::S_SHIFT: begin
        if (remaining == olsa_pkg::cnt_t'(1)) state_next = olsa_pkg::S_IDLE;
      end
      default: state_next = olsa_pkg::S_IDLE;
    endcase
  end

  // state outputs: handshake and row command
  always_comb begin
    req_ready  = 1'b0;
    chain.mode = olsa_pkg::CHAIN_HOLD;
    chain.base = erase_base;
    chain.word = olsa_pkg::word_t'(req.value);
    case (state)
      olsa_pkg::S_IDLE: begin
        req_ready = !rsp_valid || rsp_ready;
        if (req_valid && (!rsp_valid || rsp_ready)) begin
          chain.mode = dec_mode;
          chain.base = dec_base;
        end
      end
      olsa_pkg::S_SHIFT: begin
        chain.mode = olsa_pkg::CHAIN_DOWN;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= olsa_pkg::S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
      remaining <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
        remaining <= olsa_pkg::cnt_t'(run_w - 1'b1);
      end else begin
        if (rsp_ready) rsp_valid <= 1'b0;
        if (state == olsa_pkg::S_SHIFT) remaining <= remaining - 1'b1;
      end
    end
  end

  // response and erase base payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status      <= dec_status;
      rsp.read_data   <= 32'(dec_rdata);
      rsp.found       <= dec_found;
      rsp.found_index <= 4'(dec_fidx);
      rsp.fill_count  <= 5'(count_next);
      erase_base      <= dec_base;
    end
  end

  // count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= olsa_pkg::cnt_t'(olsa_pkg::CAPACITY))
    else $error("fill count above capacity");

  // a pending response always reports the current count
  a_rsp_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (olsa_pkg::cnt_t'(rsp.fill_count) == count))
    else $error("response count disagrees with list count");

  // a push on a full list reports full and leaves the count alone
  a_push_full: assert property (@(posedge clk) disable iff (rst)
    accept && full && (req.cmd == olsa_pkg::CMD_PUSH_BACK ||
                       req.cmd == olsa_pkg::CMD_PUSH_FRONT)
    |=> rsp_valid && (rsp.status == olsa_pkg::STAT_FULL) && $stable(count))
    else $error("push on full list not flagged");

  // a match index lies inside the list
  a_found_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found |-> (5'(rsp.found_index) < rsp.fill_count))
    else $error("match index beyond fill count");

  // no new item is taken while an erase is still shifting
  a_shift_block: assert property (@(posedge clk) disable iff (rst)
    (state == olsa_pkg::S_SHIFT) |-> !req_ready)
    else $error("item taken during erase shift");

endmodule

`default_nettype wire

// ----- rtl/core/ordered_list_shift_array.sv -----
// ordered list shift array: bounded list of words with shifting insert and erase
// response: registered, valid in the cycle after its item is accepted
// throughput: one item per cycle while no response is held back; an erase of a run of n > 1
//   words blocks input while the cell row shifts down, one word of shift per cycle
// reset: synchronous rst empties the list and drops any pending response;
//   cell words are not cleared and are never read before they are written
`default_nettype none

module ordered_list_shift_array (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire olsa_pkg::req_item_t req,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output olsa_pkg::rsp_item_t      rsp
);

  olsa_pkg::chain_cmd_t chain;
  olsa_pkg::word_t      cell_data [olsa_pkg::CAPACITY];
  logic [olsa_pkg::CAPACITY-1:0] cell_match;

  // sequencer
  olsa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .chain      (chain),
    .cell_data  (cell_data),
    .cell_match (cell_match)
  );

  // row of cells, each linked to its neighbors; an end cell sees zero for the missing one
  for (genvar i = 0; i < olsa_pkg::CAPACITY; i++) begin : g_cell
    olsa_pkg::word_t lower_word, upper_word;

    if (i == 0) begin : g_first
      assign lower_word = '0;
    end else begin : g_mid_lo
      assign lower_word = cell_data[i-1];
    end

    if (i == olsa_pkg::CAPACITY - 1) begin : g_last
      assign upper_word = '0;
    end else begin : g_mid_hi
      assign upper_word = cell_data[i+1];
    end

    olsa_cell u_cell (
      .clk        (clk),
      .chain      (chain),
      .cell_index (olsa_pkg::idx_t'(i)),
      .lower      (lower_word),
      .upper      (upper_word),
      .data       (cell_data[i]),
      .match      (cell_match[i])
    );
  end

endmodule

`default_nettype wire
